// File: src/u8d_pkg.sv
// Package for the UTF-8 byte stream decoder.
// Holds the decoder state and result types and the head byte length table.
// No dependencies.
package u8d_pkg;

   localparam int unsigned CpWidth   = 21;
   localparam int unsigned LenWidth  = 3;
   localparam int unsigned RemWidth  = 2;
   localparam int unsigned FlagWidth = 3;

   localparam logic [7:0] TailData  = 8'h3f;
   localparam logic [7:0] TailCheck = 8'hc0;
   localparam logic [7:0] TailMark  = 8'h80;

   // Sequence length codes; zero marks an invalid head byte
   localparam logic [LenWidth-1:0] LenInvalid = 3'd0;
   localparam logic [LenWidth-1:0] LenOne     = 3'd1;
   localparam logic [LenWidth-1:0] LenTwo     = 3'd2;
   localparam logic [LenWidth-1:0] LenThree   = 3'd3;
   localparam logic [LenWidth-1:0] LenFour    = 3'd4;

   typedef struct packed {
      logic [RemWidth-1:0]  remaining;
      logic [LenWidth-1:0]  total_len;
      logic [CpWidth-1:0]   acc;
      logic [FlagWidth-1:0] flags;
   } dec_state_type;

   typedef struct packed {
      logic [CpWidth-1:0]  code_point;
      logic                head_invalid;
      logic                second_invalid;
      logic                third_invalid;
      logic                fourth_invalid;
      logic [LenWidth-1:0] seq_length;
   } dec_result_type;

   // Sequence length picked by the top five bits of a head byte
   function automatic logic [LenWidth-1:0] head_length(input logic [4:0] top);
      logic [LenWidth-1:0] len;
      len = LenInvalid;
      if (!top[4]) begin
         len = LenOne;
      end else begin
         case (top[3:0])
            4'b1000, 4'b1001, 4'b1010, 4'b1011: len = LenTwo;
            4'b1100, 4'b1101:                   len = LenThree;
            4'b1110:                            len = LenFour;
            default:                            len = LenInvalid;
         endcase
      end
      return len;
   endfunction

endpackage

// File: src/u8d_req_if.sv
// Byte input channel of the UTF-8 decoder: valid, ready and one raw byte.
// No dependencies.
interface u8d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

// File: src/u8d_rsp_if.sv
// Codepoint result channel of the UTF-8 decoder: valid, ready and the result fields.
// No dependencies.
interface u8d_rsp_if;
   logic        valid;
   logic        ready;
   logic [20:0] code_point;
   logic        head_invalid;
   logic        second_invalid;
   logic        third_invalid;
   logic        fourth_invalid;
   logic [2:0]  seq_length;

   modport source (output valid, output code_point, output head_invalid,
                   output second_invalid, output third_invalid,
                   output fourth_invalid, output seq_length, input ready);
   modport sink   (input valid, input code_point, input head_invalid,
                   input second_invalid, input third_invalid,
                   input fourth_invalid, input seq_length, output ready);
endinterface

// File: src/u8d_step.sv
// Per-byte decode logic: next decoder state and the result a byte completes.
// Depends on u8d_pkg.
module u8d_step
   import u8d_pkg::*;
(
   input  dec_state_type  cur_state,
   input  logic [7:0]     data_byte,
   output dec_state_type  nxt_state,
   output logic           emit,
   output dec_result_type result
);

   logic [LenWidth-1:0] head_len;
   logic [LenWidth-1:0] tail_pos;
   logic [CpWidth-1:0]  tail_acc;
   logic [FlagWidth-1:0] tail_flags;
   logic                tail_bad;

   assign head_len = head_length(data_byte[7:3]);
   assign tail_pos = cur_state.total_len - LenWidth'(cur_state.remaining);
   assign tail_bad = (data_byte & TailCheck) != TailMark;
   assign tail_acc = {cur_state.acc[CpWidth-7:0], data_byte[5:0]};

   // Raise the flag of this tail position when the 10 prefix is missing
   always_comb begin
      tail_flags = cur_state.flags;
      if (tail_bad) begin
         case (tail_pos)
            LenOne:   tail_flags[0] = 1'b1;
            LenTwo:   tail_flags[1] = 1'b1;
            LenThree: tail_flags[2] = 1'b1;
            default:  tail_flags = cur_state.flags;
         endcase
      end
   end

   // Head byte when idle, tail byte otherwise
   always_comb begin
      nxt_state = cur_state;
      emit      = 1'b0;
      result    = '0;
      if (cur_state.remaining == '0) begin
         case (head_len)
            LenInvalid: begin
               emit                = 1'b1;
               result.head_invalid = 1'b1;
               result.seq_length   = LenOne;
            end
            LenOne: begin
               emit              = 1'b1;
               result.code_point = CpWidth'(data_byte);
               result.seq_length = LenOne;
            end
            LenTwo: begin
               nxt_state.acc       = CpWidth'(data_byte[4:0]);
               nxt_state.total_len = LenTwo;
               nxt_state.remaining = RemWidth'(1);
               nxt_state.flags     = '0;
            end
            LenThree: begin
               nxt_state.acc       = CpWidth'(data_byte[3:0]);
               nxt_state.total_len = LenThree;
               nxt_state.remaining = RemWidth'(2);
               nxt_state.flags     = '0;
            end
            default: begin
               nxt_state.acc       = CpWidth'(data_byte[2:0]);
               nxt_state.total_len = LenFour;
               nxt_state.remaining = RemWidth'(3);
               nxt_state.flags     = '0;
            end
         endcase
      end else begin
         nxt_state.remaining = cur_state.remaining - RemWidth'(1);
         nxt_state.acc       = tail_acc;
         nxt_state.flags     = tail_flags;
         if (cur_state.remaining == RemWidth'(1)) begin
            emit                  = 1'b1;
            result.code_point     = tail_acc;
            result.second_invalid = tail_flags[0];
            result.third_invalid  = tail_flags[1];
            result.fourth_invalid = tail_flags[2];
            result.seq_length     = cur_state.total_len;
            nxt_state.acc         = '0;
            nxt_state.flags       = '0;
            nxt_state.total_len   = '0;
         end
      end
   end

endmodule

// File: src/u8d_rsp_stage.sv
// Result register of the UTF-8 decoder with its valid flag and back-pressure.
// Depends on u8d_pkg.
module u8d_rsp_stage
   import u8d_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           load,
   input  dec_result_type load_result,
   input  logic           rsp_ready,
   output logic           rsp_valid,
   output dec_result_type rsp_result,
   output logic           has_space
);

   logic           valid_ff;
   logic           valid_in;
   dec_result_type result_ff;

   // Free when empty or when the waiting beat leaves this cycle
   assign has_space = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (has_space) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the payload until a new beat is loaded
   always_ff @(posedge clock) begin
      if (has_space && load) begin
         result_ff <= load_result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

// File: src/utf8_byte_stream_decoder.sv
// UTF-8 byte stream decoder: takes one byte per beat on req and returns one
// codepoint beat on rsp for each byte that ends a sequence (a single-byte
// character, an invalid head byte, or the last tail byte of a two to four
// byte sequence). A byte is taken in every cycle while the result register is
// free or being drained; a result appears on rsp in the cycle after the byte
// that ends it. Tail bytes lacking the 10 prefix are still consumed and
// raise the flag of their position; an invalid head gives code point zero.
// Depends on u8d_pkg, u8d_req_if, u8d_rsp_if, u8d_step and u8d_rsp_stage.
module utf8_byte_stream_decoder
   import u8d_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   u8d_req_if.sink       req,
   u8d_rsp_if.source     rsp
);

   dec_state_type  state_ff;
   dec_state_type  state_in;
   dec_state_type  step_state;
   dec_result_type step_result;
   dec_result_type rsp_result;
   logic           step_emit;
   logic           has_space;
   logic           accept;

   assign req.ready = has_space;
   assign accept    = req.valid && has_space;

   u8d_step u_step (
      .cur_state (state_ff),
      .data_byte (req.data_byte),
      .nxt_state (step_state),
      .emit      (step_emit),
      .result    (step_result)
   );

   // Advance the decoder state only on an accepted beat
   always_comb begin
      state_in = state_ff;
      if (accept) begin
         state_in = step_state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   u8d_rsp_stage u_rsp_stage (
      .clock       (clock),
      .reset       (reset),
      .load        (accept && step_emit),
      .load_result (step_result),
      .rsp_ready   (rsp.ready),
      .rsp_valid   (rsp.valid),
      .rsp_result  (rsp_result),
      .has_space   (has_space)
   );

   assign rsp.code_point     = rsp_result.code_point;
   assign rsp.head_invalid   = rsp_result.head_invalid;
   assign rsp.second_invalid = rsp_result.second_invalid;
   assign rsp.third_invalid  = rsp_result.third_invalid;
   assign rsp.fourth_invalid = rsp_result.fourth_invalid;
   assign rsp.seq_length     = rsp_result.seq_length;

endmodule

// File: src/u8d_checker.sv
// Port checker for the UTF-8 decoder, bound to the top level.
// Depends on utf8_byte_stream_decoder and its channel interfaces.
module u8d_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [20:0] code_point,
   input logic        head_invalid,
   input logic        second_invalid,
   input logic        third_invalid,
   input logic        fourth_invalid,
   input logic [2:0]  seq_length
);

   // Hold a stalled result beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(code_point)
         && $stable(seq_length) && $stable(head_invalid))
      else $error("stalled result beat changed");

   // Drop any result after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A new result needs a byte accepted in the cycle before
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid && !rsp_ready) |-> $past(req_valid && req_ready))
      else $error("result without an accepted byte");

   // Invalid head: zero code point, one byte, no tail flags
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && head_invalid |-> code_point == 21'd0 && seq_length == 3'd1
         && !second_invalid && !third_invalid && !fourth_invalid)
      else $error("bad invalid-head result");

   // Flags and code point width follow the sequence length
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (seq_length == 3'd1 && code_point < 21'd128 && !second_invalid)
         || (seq_length == 3'd2 && !head_invalid && !third_invalid && !fourth_invalid
             && code_point < 21'd2048)
         || (seq_length == 3'd3 && !head_invalid && !fourth_invalid
             && code_point < 21'd65536)
         || (seq_length == 3'd4 && !head_invalid))
      else $error("result fields disagree with length");

endmodule

bind utf8_byte_stream_decoder u8d_checker u_u8d_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .code_point     (rsp.code_point),
   .head_invalid   (rsp.head_invalid),
   .second_invalid (rsp.second_invalid),
   .third_invalid  (rsp.third_invalid),
   .fourth_invalid (rsp.fourth_invalid),
   .seq_length     (rsp.seq_length)
);
